// ----- rtl/nfd_pkg.sv -----
// NACA four-digit ordinate core: shared constants.
// Holds the polynomial coefficients, the reset thickness ratio and register indices.
// No dependencies.
`default_nettype none

package nfd_pkg;

    localparam longint COEF_DEN = 10000;
    localparam longint A_SQRT   = 2969;
    localparam longint A_LIN    = 1260;
    localparam longint A_SQR    = 3516;
    localparam longint A_CUB    = 2843;
    localparam longint A_QUAR   = 1015;

    localparam longint T_RESET_NUM = 12;
    localparam longint T_RESET_DEN = 100;

    localparam int IDX_BITS = 2;

    typedef enum logic [IDX_BITS-1:0] {
        REG_THICKNESS = 2'd0,
        REG_CAMBER    = 2'd1,
        REG_CPOS      = 2'd2
    } reg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/nfd_delay.sv -----
// Resettable delay line that keeps side-band bits in step with the pipeline.
// Advances only when the pipeline enable is high. No dependencies.
`default_nettype none

module nfd_delay #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/nfd_sqrt.sv -----
// Pipelined rounded square root of x * 2^FRAC_BITS, one root bit per stage.
// A rounding output register follows the root stages; all advance only when enabled. No dependencies.
`default_nettype none

module nfd_sqrt #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [FRAC_BITS:0]   x,
    output logic      [FRAC_BITS:0]   root
);

    localparam int N    = FRAC_BITS + 1;
    localparam int RADW = 2 * N;
    localparam int RW   = FRAC_BITS + 4;

    logic [RADW-1:0]    rad_reg  [N];
    logic [RW-1:0]      rem_reg  [N];
    logic [FRAC_BITS:0] root_reg [N];
    logic [FRAC_BITS:0] out_reg;

    logic [RADW-1:0]    rad_in   [N];
    logic [RW-1:0]      rem_in   [N];
    logic [FRAC_BITS:0] root_in  [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;

        if (i == 0)
        begin : g_first
            assign rad_in[i]  = RADW'(x) << FRAC_BITS;
            assign rem_in[i]  = '0;
            assign root_in[i] = '0;
        end
        else
        begin : g_rest
            assign rad_in[i]  = rad_reg[i-1];
            assign rem_in[i]  = rem_reg[i-1];
            assign root_in[i] = root_reg[i-1];
        end

        assign cur   = {rem_in[i][RW-3:0], rad_in[i][2*(N-1-i) +: 2]};
        assign trial = RW'({root_in[i], 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i] <= rad_in[i];
                if (cur >= trial)
                begin
                    rem_reg[i]  <= cur - trial;
                    root_reg[i] <= {root_in[i][FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= cur;
                    root_reg[i] <= {root_in[i][FRAC_BITS-1:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_reg[N-1] > RW'(root_reg[N-1]))
            begin
                out_reg <= root_reg[N-1] + 1'b1;
            end
            else
            begin
                out_reg <= root_reg[N-1];
            end
        end
    end

    assign root = out_reg;

endmodule

`default_nettype wire

// ----- rtl/nfd_div.sv -----
// Pipelined restoring divider for the camber quotient, one quotient bit per stage.
// All stages advance only when enabled. No dependencies.
`default_nettype none

module nfd_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [3*FRAC_BITS:0]     num,
    input  wire logic [2*FRAC_BITS:0]     den,
    output logic      [FRAC_BITS:0]       quo
);

    localparam int N  = FRAC_BITS + 1;
    localparam int DW = 3 * FRAC_BITS + 1;
    localparam int VW = 2 * FRAC_BITS + 1;

    logic [DW-1:0]      rem_reg [N];
    logic [VW-1:0]      den_reg [N];
    logic [FRAC_BITS:0] q_reg   [N];

    logic [DW-1:0]      rem_in  [N];
    logic [VW-1:0]      den_in  [N];
    logic [FRAC_BITS:0] q_in    [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [DW-1:0] sh;

        if (i == 0)
        begin : g_first
            assign rem_in[i] = num;
            assign den_in[i] = den;
            assign q_in[i]   = '0;
        end
        else
        begin : g_rest
            assign rem_in[i] = rem_reg[i-1];
            assign den_in[i] = den_reg[i-1];
            assign q_in[i]   = q_reg[i-1];
        end

        assign sh = DW'(den_in[i]) << (FRAC_BITS - i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[i] <= den_in[i];
                if (rem_in[i] >= sh)
                begin
                    rem_reg[i] <= rem_in[i] - sh;
                    q_reg[i]   <= {q_in[i][FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= rem_in[i];
                    q_reg[i]   <= {q_in[i][FRAC_BITS-1:0], 1'b0};
                end
            end
        end
    end

    assign quo = q_reg[N-1];

endmodule

`default_nettype wire

// ----- rtl/naca_four_digit_ordinate_core.sv -----
// NACA four-digit ordinate core: top level with Horner pipeline and final sum.
// Depends on nfd_pkg, nfd_delay, nfd_sqrt and nfd_div.
//
// Each input item is a signed chord position; each output item is the surface
// ordinate for it and a flag that is set when the ordinate was clipped.
// Both item channels use valid and stall; an item moves on an edge where valid
// is high and stall is low. The configuration channel writes the thickness
// ratio, maximum camber and camber position by index with valid and ready;
// ready is always high, and writes are expected only while the core is empty.
// The core is a single pipeline of FRAC_BITS+6 register stages, its depth set
// by the bit-serial square root that runs one root bit per stage. One item is
// accepted every cycle while the pipeline is not frozen. When the output item
// is held by out_stall the whole pipeline freezes and in_stall is raised, so
// no item is lost or repeated. Reset empties the pipeline and loads the
// default registers: thickness 0.12 and no camber.
`default_nettype none

module naca_four_digit_ordinate_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [FRAC_BITS+1:0]   chord_position,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [FRAC_BITS+1:0]        ordinate,
    output logic                               saturated,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nfd_pkg::IDX_BITS-1:0]  cfg_index,
    input  wire logic [FRAC_BITS-1:0]          cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int HW  = F + 4;
    localparam int SW  = F + 5;
    localparam int DW  = 3 * F + 1;
    localparam int VW  = 2 * F + 1;

    localparam longint HALF_C = nfd_pkg::COEF_DEN / 2;
    localparam longint K_SQRT = ((nfd_pkg::A_SQRT << F) + HALF_C) / nfd_pkg::COEF_DEN;
    localparam longint K_LIN  = ((nfd_pkg::A_LIN  << F) + HALF_C) / nfd_pkg::COEF_DEN;
    localparam longint K_SQR  = ((nfd_pkg::A_SQR  << F) + HALF_C) / nfd_pkg::COEF_DEN;
    localparam longint K_CUB  = ((nfd_pkg::A_CUB  << F) + HALF_C) / nfd_pkg::COEF_DEN;
    localparam longint K_QUAR = ((nfd_pkg::A_QUAR << F) + HALF_C) / nfd_pkg::COEF_DEN;
    localparam longint T_RST  = (nfd_pkg::T_RESET_NUM << F) / nfd_pkg::T_RESET_DEN;

    localparam logic signed [HW-1:0] C_SQRT = HW'(K_SQRT);
    localparam logic signed [HW-1:0] C_LIN  = HW'(K_LIN);
    localparam logic signed [HW-1:0] C_SQR  = HW'(K_SQR);
    localparam logic signed [HW-1:0] C_CUB  = HW'(K_CUB);
    localparam logic signed [HW-1:0] C_QUAR = HW'(K_QUAR);

    localparam logic [F+1:0]         ONE_W  = (F+2)'(1) << F;
    localparam logic [2*HW-1:0]      HALF_P = (2*HW)'(1) << (F - 1);
    localparam logic signed [SW-1:0] Y_MAX  = SW'((longint'(1) << (F + 1)) - 1);
    localparam logic signed [SW-1:0] Y_MIN  = -Y_MAX - 1;

    function automatic logic signed [HW-1:0] mulq(
        input logic [HW-1:0]        a,
        input logic signed [HW-1:0] b
    );
        logic [HW-1:0]   bm;
        logic [2*HW-1:0] p;
        logic [HW-1:0]   r;
        bm = b[HW-1] ? (~b + 1'b1) : b;
        p  = (2*HW)'(a) * (2*HW)'(bm) + HALF_P;
        r  = p[F +: HW];
        return b[HW-1] ? $signed(~r + 1'b1) : $signed(r);
    endfunction

    logic en;
    logic [F-1:0] thick_reg;
    logic [F-1:0] camber_reg;
    logic [F-1:0] cpos_reg;

    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thick_reg  <= F'(T_RST);
            camber_reg <= '0;
            cpos_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nfd_pkg::REG_THICKNESS: thick_reg  <= cfg_data;
                nfd_pkg::REG_CAMBER:    camber_reg <= cfg_data;
                nfd_pkg::REG_CPOS:      cpos_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Input stage: magnitude, clamp and camber branch selection.
    logic         neg_in;
    logic [F+1:0] mag_in;
    logic [F:0]   x_in;
    logic [F:0]   m_in;
    logic [F:0]   d_in;
    logic [F:0]   e_in;

    assign neg_in = chord_position[F+1];
    assign mag_in = neg_in ? (~chord_position + 1'b1) : chord_position;
    assign x_in   = (mag_in > ONE_W) ? ONE_W[F:0] : mag_in[F:0];
    assign m_in   = (F+1)'(cpos_reg);
    assign d_in   = (x_in <= m_in) ? m_in : (ONE_W[F:0] - m_in);
    assign e_in   = (x_in <= m_in) ? (m_in - x_in) : (x_in - m_in);

    logic         valid1_reg;
    logic         neg1_reg;
    logic [F:0]   x1_reg;
    logic [F:0]   d1_reg;
    logic [F:0]   e1_reg;
    logic         on1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= neg_in;
            x1_reg   <= x_in;
            d1_reg   <= d_in;
            e1_reg   <= e_in;
            on1_reg  <= (camber_reg != '0) && (cpos_reg != '0);
        end
    end

    // Horner evaluation of the polynomial part.
    logic [F:0]          x2_reg;
    logic [F:0]          x3_reg;
    logic [F:0]          x4_reg;
    logic signed [HW-1:0] h1_reg;
    logic signed [HW-1:0] h2_reg;
    logic signed [HW-1:0] h3_reg;
    logic signed [HW-1:0] h4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg <= x1_reg;
            x3_reg <= x2_reg;
            x4_reg <= x3_reg;
            h1_reg <= C_CUB - mulq(HW'(x1_reg), C_QUAR);
            h2_reg <= mulq(HW'(x2_reg), h1_reg) - C_SQR;
            h3_reg <= mulq(HW'(x3_reg), h2_reg) - C_LIN;
            h4_reg <= mulq(HW'(x4_reg), h3_reg);
        end
    end

    logic [F:0]    root;
    logic [HW-1:0] h4_dly;

    nfd_sqrt #(
        .FRAC_BITS(F)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .x    (x1_reg),
        .root (root)
    );

    nfd_delay #(
        .WIDTH(HW),
        .DEPTH(F - 2)
    ) u_h_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (h4_reg),
        .dout  (h4_dly)
    );

    logic [1:0] side_dly;

    nfd_delay #(
        .WIDTH(2),
        .DEPTH(F + 4)
    ) u_side_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   ({valid1_reg, neg1_reg}),
        .dout  (side_dly)
    );

    logic signed [HW-1:0] yt_reg;
    logic signed [HW-1:0] ys_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yt_reg <= mulq(C_SQRT, $signed(HW'(root))) + $signed(h4_dly);
            ys_reg <= mulq(HW'(thick_reg) * HW'(5), yt_reg);
        end
    end

    // Camber numerator and denominator ahead of the divider.
    logic [VW-1:0] d2_reg;
    logic [VW-1:0] e2_reg;
    logic          on2_reg;
    logic [VW-1:0] d2b_reg;
    logic [VW-1:0] diff_reg;
    logic          on3_reg;
    logic [DW-1:0] num_reg;
    logic [VW-1:0] den_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg   <= VW'(d1_reg) * VW'(d1_reg);
            e2_reg   <= VW'(e1_reg) * VW'(e1_reg);
            on2_reg  <= on1_reg;
            d2b_reg  <= d2_reg;
            diff_reg <= d2_reg - e2_reg;
            on3_reg  <= on2_reg;
            if (on3_reg)
            begin
                num_reg <= DW'(camber_reg) * DW'(diff_reg) + DW'(d2b_reg >> 1);
                den_reg <= d2b_reg;
            end
            else
            begin
                num_reg <= '0;
                den_reg <= VW'(1);
            end
        end
    end

    logic [F:0] quo;

    nfd_div #(
        .FRAC_BITS(F)
    ) u_div (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    // Sign, camber sum and saturation into the output register.
    logic signed [HW-1:0] yn;
    logic signed [SW-1:0] sum;
    logic                 out_valid_reg;
    logic signed [F+1:0]  ord_reg;
    logic                 sat_reg;

    assign yn  = side_dly[0] ? -ys_reg : ys_reg;
    assign sum = $signed({yn[HW-1], yn}) + $signed({4'b0000, quo});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= side_dly[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sum > Y_MAX)
            begin
                ord_reg <= Y_MAX[F+1:0];
                sat_reg <= 1'b1;
            end
            else if (sum < Y_MIN)
            begin
                ord_reg <= Y_MIN[F+1:0];
                sat_reg <= 1'b1;
            end
            else
            begin
                ord_reg <= sum[F+1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign ordinate  = ord_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_naca_four_digit_ordinate_checker.sv -----
// Checker for the NACA four-digit ordinate core: watches both item channels,
// predicts each ordinate from the current register settings and compares.
// Depends on nfd_pkg for register indices.
`timescale 1ns / 1ps

module tb_naca_four_digit_ordinate_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [17:0] chord_position,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [17:0] ordinate,
    input  logic               saturated,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam longint ONE = 64'd65536;

    typedef struct packed {
        logic signed [17:0] y;
        logic               sat;
    } ordinate_t;

    ordinate_t   expected_q[$];
    logic [15:0] t_ratio;
    logic [15:0] p_camber;
    logic [15:0] m_pos;

    function automatic longint coef(longint n);
        return ((n << 16) + nfd_pkg::COEF_DEN / 2) / nfd_pkg::COEF_DEN;
    endfunction

    function automatic longint mul_round(longint a, longint b);
        longint ma;
        longint mb;
        longint r;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        r  = (ma * mb + ONE / 2) >>> 16;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint root_round(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r = r + 1;
        if (v - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic ordinate_t surface_ordinate(logic signed [17:0] pos);
        ordinate_t  res;
        logic       lower;
        longint     xm;
        longint     h;
        longint     y;
        longint     d;
        longint     e;
        logic [127:0] num;
        logic [127:0] den;
        lower = pos < 0;
        xm = lower ? -longint'(pos) : longint'(pos);
        if (xm > ONE)
            xm = ONE;
        h = -coef(nfd_pkg::A_QUAR);
        h = coef(nfd_pkg::A_CUB) + mul_round(xm, h);
        h = -coef(nfd_pkg::A_SQR) + mul_round(xm, h);
        h = -coef(nfd_pkg::A_LIN) + mul_round(xm, h);
        h = mul_round(xm, h);
        h = mul_round(coef(nfd_pkg::A_SQRT), root_round(xm << 16)) + h;
        y = mul_round(h, 5 * longint'(t_ratio));
        if (lower)
            y = -y;
        if (p_camber != 0 && m_pos != 0)
        begin
            if (xm <= m_pos)
            begin
                d = m_pos;
                e = m_pos - xm;
            end
            else
            begin
                d = ONE - m_pos;
                e = xm - m_pos;
            end
            den = 128'(d * d);
            num = 128'(p_camber) * 128'(d * d - e * e) + (den >> 1);
            y = y + longint'(num / den);
        end
        res.sat = 1'b0;
        if (y > 131071)
        begin
            y = 131071;
            res.sat = 1'b1;
        end
        if (y < -131072)
        begin
            y = -131072;
            res.sat = 1'b1;
        end
        res.y = y[17:0];
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        ordinate_t want;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            expected_q.delete();
            t_ratio    <= 16'd7864;
            p_camber   <= 16'd0;
            m_pos      <= 16'd0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (nfd_pkg::reg_idx_t'(cfg_index))
                    nfd_pkg::REG_THICKNESS: t_ratio  <= cfg_data;
                    nfd_pkg::REG_CAMBER:    p_camber <= cfg_data;
                    nfd_pkg::REG_CPOS:      m_pos    <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_q.push_back(surface_ordinate(chord_position));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected item: ordinate %0d", ordinate);
                    errs = errs + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.y !== ordinate)
                    begin
                        $error("ordinate: expected %0d, actual %0d", want.y, ordinate);
                        errs = errs + 1;
                    end
                    if (want.sat !== saturated)
                    begin
                        $error("saturated: expected %0d, actual %0d", want.sat, saturated);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

// ----- tb/sv/tb_naca_four_digit_ordinate_core.sv -----
// Testbench top for the NACA four-digit ordinate core: drives positions and
// register settings with random gaps and stalls, and gives the verdict.
// Depends on nfd_pkg, the core and tb_naca_four_digit_ordinate_checker.
`timescale 1ns / 1ps

module tb_naca_four_digit_ordinate_core;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [17:0] chord_position;
    logic               out_valid;
    logic               out_stall;
    logic signed [17:0] ordinate;
    logic               saturated;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    int                 fail_count;
    int                 pending;
    int                 hold_off;
    logic               stall_random;

    naca_four_digit_ordinate_core DUT (.*);

    tb_naca_four_digit_ordinate_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb_naca_four_digit_ordinate_core: errors");
        $finish;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls, with a long hold-off on request.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                hold_off  = hold_off - 1;
            end
            else if (!stall_random)
                out_stall <= 1'b0;
            else
            begin
                n = gap_length();
                out_stall <= n != 0;
                repeat (n > 0 ? n - 1 : 0) @(negedge clk);
            end
        end
    end

    task automatic send_position(logic signed [17:0] pos, bit gaps);
        int n;
        n = gaps ? gap_length() : 0;
        repeat (n)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        chord_position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(nfd_pkg::reg_idx_t idx, logic [15:0] value);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic signed [17:0] random_position();
        case ($urandom_range(0, 9))
            0: return 18'($urandom());
            1: return 18'sd65536 - 18'($urandom_range(0, 3));
            2: return -18'sd65536 + 18'($urandom_range(0, 3));
            default: return 18'($urandom_range(0, 131072)) - 18'sd65536;
        endcase
    endfunction

    initial
    begin
        logic signed [17:0] edge_pos[12];
        logic [15:0] t_set[5];
        logic [15:0] p_set[5];
        logic [15:0] m_set[5];
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        chord_position = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        hold_off       = 0;
        stall_random   = 1'b0;
        edge_pos = '{18'sd0, 18'sd1, -18'sd1, 18'sd65536, -18'sd65536, 18'sd65537,
                     18'sd131071, -18'sd131072, -18'sd131071, 18'sd32768,
                     -18'sd19661, 18'sd100};
        t_set = '{16'd7864, 16'hFFFF, 16'd0, 16'd1, 16'd13107};
        p_set = '{16'd0, 16'd1311, 16'hFFFF, 16'd1, 16'd3000};
        m_set = '{16'd0, 16'd26214, 16'hFFFF, 16'd1, 16'd32768};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (edge_pos[i])
            send_position(edge_pos[i], 1'b0);
        drain();
        write_register(nfd_pkg::REG_THICKNESS, 16'hFFFF);
        write_register(nfd_pkg::REG_CAMBER, 16'hFFFF);
        write_register(nfd_pkg::REG_CPOS, 16'd26214);
        foreach (edge_pos[i])
            send_position(edge_pos[i], 1'b0);
        drain();

        // The receiver holds off while items keep coming, so the core fills.
        hold_off = 80;
        repeat (60) send_position(random_position(), 1'b0);
        drain();

        stall_random = 1'b1;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_register(nfd_pkg::REG_THICKNESS, t_set[phase]);
            write_register(nfd_pkg::REG_CAMBER, p_set[(phase + 2) % 5]);
            write_register(nfd_pkg::REG_CPOS, m_set[phase]);
            repeat (200) send_position(random_position(), phase != 2);
            drain();
        end

        if (fail_count == 0)
            $display("tb_naca_four_digit_ordinate_core: clean");
        else
            $display("tb_naca_four_digit_ordinate_core: errors");
        $finish;
    end
endmodule
